// ===== design/lrukt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrukt_pkg
// Types and constants shared by the resident key tracker.
// ----------------------------------------------------------------------------
package lrukt_pkg;

    localparam int KEY_W = 4;
    localparam int CAP_W = 4;
    localparam int CNT_W = 4;
    localparam int RES_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4);

    localparam logic [RES_W-1:0] EV_HIT     = 2'd0;
    localparam logic [RES_W-1:0] EV_LOADED  = 2'd1;
    localparam logic [RES_W-1:0] EV_FAILED  = 2'd2;
    localparam logic [RES_W-1:0] EV_EVICTED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_EVICT_RD,
        ST_EVICT_OUT,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_RESULT
    } t_state;

endpackage

// ===== design/lru_resident_key_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_resident_key_tracker_unit
// Tracks resident keys in recency order and reports hits, loads and evictions.
// ----------------------------------------------------------------------------
// One request at a time is handled by a small sequencer walking a recency
// memory of MAX_ENTRIES keys (slot 0 most recent) with a single read/write
// port and one key comparator. The memory port sets the pace: each visited
// slot is read and then compared or written back. A hit at slot h searches
// slots 0..h and rotates them; a miss searches every resident key, and if its
// load is allowed evicts from the tail while the set is at capacity, shifts
// the keys down one slot with the new key entering slot 0 and then hands over
// the result. Results wait in an output register; the sequencer holds while
// that register is stalled. An evicted key is reported before the final
// loaded result, which carries o_last high.
module lru_resident_key_tracker_unit
    import lrukt_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_load_ok,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [RES_W-1:0] o_event_res,
    output logic [KEY_W-1:0] o_event_key,
    output logic [CNT_W-1:0] o_resident_count,
    output logic             o_last
);

    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    function automatic logic evict_needed(input logic [OCC_W-1:0] occ,
                                          input logic [OCC_W-1:0] ecap);
        evict_needed = (occ >= ecap) && (occ != '0);
    endfunction

    logic [KEY_W-1:0] r_mem [MAX_ENTRIES];

    t_state           r_state, n_state;
    logic [CAP_W-1:0] r_cap;
    logic [OCC_W-1:0] r_occ, n_occ;
    logic [OCC_W-1:0] r_ecap, n_ecap;
    logic [OCC_W-1:0] r_idx, n_idx;
    logic [OCC_W-1:0] r_end, n_end;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_ok, n_ok;
    logic             r_hit, n_hit;
    logic [KEY_W-1:0] r_carry, n_carry;
    logic [RES_W-1:0] r_res, n_res;
    logic [KEY_W-1:0] r_rdata;

    logic             r_out_valid, n_out_valid;
    logic [RES_W-1:0] r_out_res, n_out_res;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic [CNT_W-1:0] r_out_count, n_out_count;
    logic             r_out_last, n_out_last;

    logic             in_acc;
    logic             out_free;
    logic             mem_we;
    logic [IDX_W-1:0] mem_addr;
    logic [OCC_W-1:0] occ_m1;
    logic [31:0]      cap_lim;
    logic             srch_last;
    logic             rot_done;

    assign in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign occ_m1    = r_occ - OCC_W'(1);
    assign srch_last = (r_idx + OCC_W'(1)) == r_occ;
    assign rot_done  = (r_idx == r_end);

    // clamp of the capacity register
    always_comb begin
        cap_lim = (r_cap == '0) ? 32'd1 : 32'(r_cap);
        if (cap_lim > 32'(MAX_ENTRIES)) begin
            cap_lim = 32'(MAX_ENTRIES);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (r_occ != '0) begin
                        n_state = ST_SRCH_RD;
                    end else if (!i_load_ok) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_ROT_RD;
                    end
                end
            end
            ST_SRCH_RD: n_state = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                if (r_rdata == r_key) begin
                    n_state = ST_ROT_RD;
                end else if (srch_last) begin
                    if (!r_ok) begin
                        n_state = ST_RESULT;
                    end else if (evict_needed(r_occ, r_ecap)) begin
                        n_state = ST_EVICT_RD;
                    end else begin
                        n_state = ST_ROT_RD;
                    end
                end else begin
                    n_state = ST_SRCH_RD;
                end
            end
            ST_EVICT_RD: n_state = ST_EVICT_OUT;
            ST_EVICT_OUT: begin
                if (out_free) begin
                    n_state = evict_needed(occ_m1, r_ecap) ? ST_EVICT_RD : ST_ROT_RD;
                end
            end
            ST_ROT_RD: n_state = ST_ROT_WR;
            ST_ROT_WR: n_state = rot_done ? ST_RESULT : ST_ROT_RD;
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_occ       = r_occ;
        n_ecap      = r_ecap;
        n_idx       = r_idx;
        n_end       = r_end;
        n_key       = r_key;
        n_ok        = r_ok;
        n_hit       = r_hit;
        n_carry     = r_carry;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_res   = r_out_res;
        n_out_key   = r_out_key;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_addr    = r_idx[IDX_W-1:0];
        o_in_stall  = (r_state != ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_key   = i_key;
                    n_ok    = i_load_ok;
                    n_ecap  = OCC_W'(cap_lim);
                    n_idx   = '0;
                    n_end   = '0;
                    n_hit   = 1'b0;
                    n_carry = i_key;
                    n_res   = i_load_ok ? EV_LOADED : EV_FAILED;
                end
            end
            ST_SRCH_CMP: begin
                if (r_rdata == r_key) begin
                    n_hit = 1'b1;
                    n_res = EV_HIT;
                    n_end = r_idx;
                    n_idx = '0;
                end else if (srch_last) begin
                    n_idx = '0;
                    n_end = r_occ;
                end else begin
                    n_idx = r_idx + OCC_W'(1);
                end
            end
            ST_EVICT_RD: begin
                mem_addr = occ_m1[IDX_W-1:0];
            end
            ST_EVICT_OUT: begin
                // keep the victim on the read port while the output is held
                mem_addr = occ_m1[IDX_W-1:0];
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_res   = EV_EVICTED;
                    n_out_key   = r_rdata;
                    n_out_count = CNT_W'(occ_m1);
                    n_out_last  = 1'b0;
                    n_occ       = occ_m1;
                    n_end       = occ_m1;
                end
            end
            ST_ROT_WR: begin
                mem_we  = 1'b1;
                n_carry = r_rdata;
                if (rot_done) begin
                    if (!r_hit) begin
                        n_occ = r_occ + OCC_W'(1);
                    end
                end else begin
                    n_idx = r_idx + OCC_W'(1);
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_out_key   = r_key;
                    n_out_count = CNT_W'(r_occ);
                    n_out_last  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // recency memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_carry;
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ecap      <= n_ecap;
        r_idx       <= n_idx;
        r_end       <= n_end;
        r_key       <= n_key;
        r_ok        <= n_ok;
        r_hit       <= n_hit;
        r_carry     <= n_carry;
        r_res       <= n_res;
        r_out_res   <= n_out_res;
        r_out_key   <= n_out_key;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_out_res;
    assign o_event_key      = r_out_key;
    assign o_resident_count = r_out_count;
    assign o_last           = r_out_last;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the resident key tracker. A table of directed
// requests and capacity writes is followed by random phases under varied
// idling, a long output hold-off and a fully drained phase. Each accepted
// request is run through a recency-list predictor and every result is
// checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
    import lrukt_pkg::*;

    localparam int LRU_DEPTH  = 8;
    localparam int LIMIT      = 200000;
    localparam int SETTLE     = 10;
    localparam int HOLD_LEN   = 300;
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 25;
    localparam int ROWS       = 28;

    typedef struct packed {
        logic [RES_W-1:0] res;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } t_lru_event;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [KEY_W-1:0] val;
        logic             ok;
        logic             typed;
        logic [RES_W-1:0] res;
        logic [CNT_W-1:0] cnt;
    } t_directed_row;

    localparam t_directed_row DIRECTED [ROWS] = '{
        '{ROW_REQ, 4'd0,  1'b0, 1'b1, EV_FAILED, 4'd0},
        '{ROW_REQ, 4'd15, 1'b1, 1'b1, EV_LOADED, 4'd1},
        '{ROW_REQ, 4'd15, 1'b0, 1'b1, EV_HIT,    4'd1},
        '{ROW_REQ, 4'd0,  1'b1, 1'b1, EV_LOADED, 4'd2},
        '{ROW_REQ, 4'd5,  1'b1, 1'b1, EV_LOADED, 4'd3},
        '{ROW_REQ, 4'd10, 1'b1, 1'b1, EV_LOADED, 4'd4},
        '{ROW_REQ, 4'd3,  1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd0,  1'b0, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd15, 1'b0, 1'b1, EV_FAILED, 4'd4},
        '{ROW_CFG, 4'd1,  1'b0, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd5,  1'b1, 1'b1, EV_HIT,    4'd4},
        '{ROW_REQ, 4'd9,  1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd9,  1'b0, 1'b1, EV_HIT,    4'd1},
        '{ROW_CFG, 4'd0,  1'b0, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd12, 1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_CFG, 4'd15, 1'b0, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd1,  1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd2,  1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd4,  1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd6,  1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd7,  1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd8,  1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd11, 1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd13, 1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd14, 1'b0, 1'b1, EV_FAILED, 4'd8},
        '{ROW_CFG, 4'd1,  1'b0, 1'b0, EV_HIT,    4'd0},
        '{ROW_REQ, 4'd14, 1'b1, 1'b0, EV_HIT,    4'd0},
        '{ROW_CFG, 4'd4,  1'b0, 1'b0, EV_HIT,    4'd0}
    };

    localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES] = '{
        4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd6, 4'd2, 4'd5
    };
    localparam int SEND_IDLE [4] = '{0, 85, 0, 7};
    localparam int RECV_IDLE [4] = '{0, 0, 85, 7};

    logic             i_clk;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [CAP_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [KEY_W-1:0] i_key      = '0;
    logic             i_load_ok  = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [RES_W-1:0] o_event_res;
    logic [KEY_W-1:0] o_event_key;
    logic [CNT_W-1:0] o_resident_count;
    logic             o_last;

    logic [KEY_W-1:0] lru_keys [LRU_DEPTH];
    int unsigned      lru_fill     = 0;
    logic [CAP_W-1:0] capacity_reg = CAP_RESET;
    t_lru_event       step_events [$];
    t_lru_event       pending_events [$];

    int  send_idle_pct = 7;
    int  stall_pct     = 7;
    bit  hold_start    = 1'b0;
    int  hold_left     = 0;
    int  bad_results   = 0;
    int  cycle_count   = 0;

    lru_resident_key_tracker_unit #(
        .MAX_ENTRIES(LRU_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_key           (i_key),
        .i_load_ok       (i_load_ok),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_res     (o_event_res),
        .o_event_key     (o_event_key),
        .o_resident_count(o_resident_count),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // recency list: slot 0 most recent, evictions taken from the tail
    function automatic void lru_step(input logic [KEY_W-1:0] k, input logic ok);
        int unsigned eff;
        int          hit_at;
        t_lru_event  ev;
        step_events.delete();
        eff = (capacity_reg == 0) ? 1 :
              (capacity_reg > LRU_DEPTH) ? LRU_DEPTH : capacity_reg;
        hit_at = -1;
        for (int i = 0; i < lru_fill; i++) begin
            if (hit_at < 0 && lru_keys[i] == k) hit_at = i;
        end
        if (hit_at >= 0) begin
            for (int j = hit_at; j > 0; j--) lru_keys[j] = lru_keys[j-1];
            lru_keys[0] = k;
            ev = '{EV_HIT, k, CNT_W'(lru_fill), 1'b1};
            step_events = {step_events, ev};
            return;
        end
        if (!ok) begin
            ev = '{EV_FAILED, k, CNT_W'(lru_fill), 1'b1};
            step_events = {step_events, ev};
            return;
        end
        while (lru_fill >= eff && lru_fill > 0) begin
            lru_fill--;
            ev = '{EV_EVICTED, lru_keys[lru_fill], CNT_W'(lru_fill), 1'b0};
            step_events = {step_events, ev};
        end
        for (int j = lru_fill; j > 0; j--) lru_keys[j] = lru_keys[j-1];
        lru_keys[0] = k;
        lru_fill++;
        ev = '{EV_LOADED, k, CNT_W'(lru_fill), 1'b1};
        step_events = {step_events, ev};
    endfunction

    task automatic offer_request(input logic [KEY_W-1:0] k, input logic ok,
                                 input logic typed, input logic [RES_W-1:0] t_res,
                                 input logic [CNT_W-1:0] t_cnt);
        int         gap;
        t_lru_event ev;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_key      <= k;
        i_load_ok  <= ok;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        lru_step(k, ok);
        if (typed) begin
            ev = '{t_res, k, t_cnt, 1'b1};
            pending_events = {pending_events, ev};
        end else begin
            pending_events = {pending_events, step_events};
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        capacity_reg = v;
    endtask

    // result checker and output stall generator
    always @(posedge i_clk) begin
        t_lru_event got;
        t_lru_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_event_res, o_event_key, o_resident_count, o_last};
            if (pending_events.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result: res=%0d key=%0d count=%0d last=%0d",
                             got.res, got.key, got.cnt, got.last);
            end else begin
                want = pending_events.pop_front();
                if (got.res !== want.res || got.key !== want.key ||
                    got.cnt !== want.cnt || got.last !== want.last) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("mismatch: expected res=%0d key=%0d count=%0d last=%0d, %s%0d %s%0d %s%0d %s%0d",
                                 want.res, want.key, want.cnt, want.last,
                                 "got res=", got.res, "key=", got.key,
                                 "count=", got.cnt, "last=", got.last);
                end
            end
        end
        if (hold_start) begin
            hold_left  = HOLD_LEN;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin
        logic [KEY_W-1:0] k;
        logic             ok;
        int               pool;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_capacity(DIRECTED[r].val);
            end else begin
                offer_request(DIRECTED[r].val, DIRECTED[r].ok, DIRECTED[r].typed,
                              DIRECTED[r].res, DIRECTED[r].cnt);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(PHASE_CAPS[p]);
            send_idle_pct = SEND_IDLE[p % 4];
            stall_pct     = RECV_IDLE[p % 4];
            // long output hold-off so the block backs up and stalls its input
            if (p == 2) hold_start = 1'b1;
            pool = ((capacity_reg > LRU_DEPTH) ? LRU_DEPTH : capacity_reg) + 2;
            for (int n = 0; n < PHASE_REQS; n++) begin
                if ($urandom_range(0, 3) == 0) k = KEY_W'($urandom_range(0, 15));
                else k = KEY_W'($urandom_range(0, pool));
                ok = ($urandom_range(0, 3) != 0);
                offer_request(k, ok, 1'b0, EV_HIT, '0);
                if (p == 5) wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE * 2) @(posedge i_clk);
        if (bad_results == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
